// ===== design/dirty_page_tracker_run_coalescer_unit_assert.svh =====
// Assertion macros for the run coalescer.
// DPRC_ASSERT_IMP: same-cycle implication, DPRC_ASSERT_NXT: next-cycle implication.
`ifndef DIRTY_PAGE_TRACKER_RUN_COALESCER_UNIT_ASSERT_SVH
`define DIRTY_PAGE_TRACKER_RUN_COALESCER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DPRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DPRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DPRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DPRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/dprc_pkg.sv =====
package dprc_pkg;

  localparam int MAX_PAGES  = 64;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int RESULT_CAP = 32;
  localparam int RUN_CAP    = 64;

  localparam int PG_W   = 6;   // page index
  localparam int PC_W   = 7;   // page count / end page
  localparam int SO_W   = 12;  // start offset
  localparam int OFF_W  = 19;  // byte offsets and counts
  localparam int KIND_W = 3;
  localparam int CNT_W  = 6;   // results emitted, 0..RESULT_CAP
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_TOTAL_PAGES  = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAP_FIRST    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAP_END      = 3'd2;
  localparam logic [IDX_W-1:0] REG_START_OFFSET = 3'd3;
  localparam logic [IDX_W-1:0] REG_BYTE_COUNT   = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_DIRTIED   = 3'd0,
    KIND_ALREADY   = 3'd1,
    KIND_OUT_RANGE = 3'd2,
    KIND_RUN       = 3'd3,
    KIND_NONE      = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FAULT,
    ST_FIND,
    ST_EXTENT,
    ST_EMIT,
    ST_NONE,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic accept;
    logic fault_load;
    logic find;
    logic extent;
    logic emit;
    logic none_load;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic found;
    logic count_zero;
    logic emit_last;
  } dp_status_t;

  // bit i set where i >= p
  function automatic logic [MAX_PAGES-1:0] ge_mask(input logic [PC_W-1:0] p);
    logic [MAX_PAGES-1:0] m;
    for (int i = 0; i < MAX_PAGES; i++) m[i] = (PC_W'(i) >= p);
    return m;
  endfunction

  // bit i set where i < e
  function automatic logic [MAX_PAGES-1:0] lt_mask(input logic [PC_W-1:0] e);
    logic [MAX_PAGES-1:0] m;
    for (int i = 0; i < MAX_PAGES; i++) m[i] = (PC_W'(i) < e);
    return m;
  endfunction

  // lowest set bit; top bit acts as sentinel
  function automatic logic [PC_W-1:0] first_set(input logic [MAX_PAGES:0] v);
    logic [PC_W-1:0] p;
    p = PC_W'(MAX_PAGES);
    for (int i = MAX_PAGES; i >= 0; i--) begin
      if (v[i]) p = PC_W'(i);
    end
    return p;
  endfunction

endpackage

// ===== design/dirty_page_tracker_run_coalescer_unit.sv =====
// Fault word: the FAULT state loads the result into the output register once it is free.
// Commit word: each run passes through find, extent and emit, the emit waiting for a free
// output register; then a clear step. With nothing dirty, a none word is loaded instead.
// A result word left waiting in the output register holds the controller until taken.
// Next word is taken after the last result is loaded and, for a commit, after the clear.
// rst_n is synchronous, active low: dirty map cleared, config at its reset values.
module dirty_page_tracker_run_coalescer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dprc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [dprc_pkg::OFF_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [dprc_pkg::PG_W-1:0]      in_page_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dprc_pkg::KIND_W-1:0]    out_kind,
  output logic [dprc_pkg::PG_W-1:0]      out_first_page,
  output logic [dprc_pkg::PC_W-1:0]      out_page_count,
  output logic                           out_became_dirty,
  output logic [dprc_pkg::OFF_W-1:0]     out_gl_offset,
  output logic [dprc_pkg::OFF_W-1:0]     out_shadow_offset,
  output logic [dprc_pkg::OFF_W-1:0]     out_byte_count,
  output logic                           out_last
);

  dprc_pkg::ctrl_cmd_t  cmd;
  dprc_pkg::dp_status_t sts;

  dprc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dprc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_page_index     (in_page_index),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_first_page    (out_first_page),
    .out_page_count    (out_page_count),
    .out_became_dirty  (out_became_dirty),
    .out_gl_offset     (out_gl_offset),
    .out_shadow_offset (out_shadow_offset),
    .out_byte_count    (out_byte_count),
    .out_last          (out_last)
  );

endmodule

// ===== design/dprc_ctrl.sv =====
module dprc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_action,
  output logic                 in_ready,
  input  dprc_pkg::dp_status_t sts,
  output dprc_pkg::ctrl_cmd_t  cmd
);

  dprc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dprc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      dprc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = in_action ? dprc_pkg::ST_FIND : dprc_pkg::ST_FAULT;
        end
      end
      dprc_pkg::ST_FAULT: begin
        if (sts.out_free) begin
          cmd.fault_load = 1'b1;
          state_nxt      = dprc_pkg::ST_IDLE;
        end
      end
      dprc_pkg::ST_FIND: begin
        cmd.find = 1'b1;
        if (sts.found) begin
          state_nxt = dprc_pkg::ST_EXTENT;
        end else if (sts.count_zero) begin
          state_nxt = dprc_pkg::ST_NONE;
        end else begin
          state_nxt = dprc_pkg::ST_CLEAR;
        end
      end
      dprc_pkg::ST_EXTENT: begin
        cmd.extent = 1'b1;
        state_nxt  = dprc_pkg::ST_EMIT;
      end
      dprc_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.emit_last ? dprc_pkg::ST_CLEAR : dprc_pkg::ST_FIND;
        end
      end
      dprc_pkg::ST_NONE: begin
        if (sts.out_free) begin
          cmd.none_load = 1'b1;
          state_nxt     = dprc_pkg::ST_CLEAR;
        end
      end
      dprc_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = dprc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = dprc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/dprc_dp.sv =====
`include "dirty_page_tracker_run_coalescer_unit_assert.svh"

module dprc_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dprc_pkg::IDX_W-1:0]          cfg_index,
  input  logic [dprc_pkg::OFF_W-1:0]          cfg_wdata,
  input  logic [dprc_pkg::PG_W-1:0]           in_page_index,
  input  dprc_pkg::ctrl_cmd_t                 cmd,
  output dprc_pkg::dp_status_t                sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [dprc_pkg::KIND_W-1:0]         out_kind,
  output logic [dprc_pkg::PG_W-1:0]           out_first_page,
  output logic [dprc_pkg::PC_W-1:0]           out_page_count,
  output logic                                out_became_dirty,
  output logic [dprc_pkg::OFF_W-1:0]          out_gl_offset,
  output logic [dprc_pkg::OFF_W-1:0]          out_shadow_offset,
  output logic [dprc_pkg::OFF_W-1:0]          out_byte_count,
  output logic                                out_last
);

  localparam logic [dprc_pkg::PC_W-1:0] NPAGES = dprc_pkg::PC_W'(dprc_pkg::MAX_PAGES);
  localparam logic [dprc_pkg::PC_W:0]   RCAP   = (dprc_pkg::PC_W+1)'(dprc_pkg::RUN_CAP);
  localparam logic [dprc_pkg::CNT_W-1:0] CNT_LAST =
    dprc_pkg::CNT_W'(dprc_pkg::RESULT_CAP - 1);

  // configuration
  logic [dprc_pkg::PC_W-1:0]  cfg_total_r;
  logic [dprc_pkg::PG_W-1:0]  cfg_first_r;
  logic [dprc_pkg::PC_W-1:0]  cfg_end_r;
  logic [dprc_pkg::SO_W-1:0]  cfg_start_r;
  logic [dprc_pkg::OFF_W-1:0] cfg_bytes_r;

  // tracking state
  logic [dprc_pkg::MAX_PAGES-1:0] dirty_map_r;
  logic [dprc_pkg::PC_W-1:0]      run_length_r;
  logic [dprc_pkg::PG_W-1:0]      last_run_end_r;
  logic                           last_run_valid_r;
  logic                           any_dirty_r;

  // item and scan
  logic [dprc_pkg::PG_W-1:0]  page_r;
  logic [dprc_pkg::PC_W-1:0]  pos_r;
  logic [dprc_pkg::PG_W-1:0]  run_first_r;
  logic [dprc_pkg::PC_W-1:0]  run_end_r;
  logic [dprc_pkg::CNT_W-1:0] count_r;

  // output word
  logic                       out_valid_r;
  dprc_pkg::kind_t            out_kind_r;
  logic [dprc_pkg::PG_W-1:0]  out_first_r;
  logic [dprc_pkg::PC_W-1:0]  out_count_r;
  logic                       out_bd_r;
  logic [dprc_pkg::OFF_W-1:0] out_gl_r;
  logic [dprc_pkg::OFF_W-1:0] out_sh_r;
  logic [dprc_pkg::OFF_W-1:0] out_bc_r;
  logic                       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_total_r <= NPAGES;
      cfg_first_r <= '0;
      cfg_end_r   <= NPAGES;
      cfg_start_r <= '0;
      cfg_bytes_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dprc_pkg::REG_TOTAL_PAGES:  cfg_total_r <= cfg_wdata[dprc_pkg::PC_W-1:0];
        dprc_pkg::REG_MAP_FIRST:    cfg_first_r <= cfg_wdata[dprc_pkg::PG_W-1:0];
        dprc_pkg::REG_MAP_END:      cfg_end_r   <= cfg_wdata[dprc_pkg::PC_W-1:0];
        dprc_pkg::REG_START_OFFSET: cfg_start_r <= cfg_wdata[dprc_pkg::SO_W-1:0];
        dprc_pkg::REG_BYTE_COUNT:   cfg_bytes_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // page limits
  logic [dprc_pkg::PC_W-1:0] n_pages;
  logic [dprc_pkg::PC_W-1:0] scan_end;
  logic [dprc_pkg::MAX_PAGES-1:0] span_map;

  assign n_pages  = (cfg_total_r < NPAGES) ? cfg_total_r : NPAGES;
  assign scan_end = (cfg_end_r < n_pages) ? cfg_end_r : n_pages;
  assign span_map = dirty_map_r & dprc_pkg::lt_mask(scan_end);

  // fault path
  logic                           f_oor, f_hit, f_chain;
  logic [dprc_pkg::PC_W:0]        rl_dbl, f_end_w;
  logic [dprc_pkg::PC_W-1:0]      rl_new, f_end;
  logic [dprc_pkg::MAX_PAGES-1:0] f_mask;
  dprc_pkg::kind_t                f_kind;

  always_comb begin
    f_oor   = {1'b0, page_r} >= n_pages;
    f_hit   = dirty_map_r[page_r];
    f_chain = last_run_valid_r && (page_r != '0) &&
              ({1'b0, page_r} == ({1'b0, last_run_end_r} + 7'd1)) &&
              dirty_map_r[page_r - 6'd1];
    rl_dbl  = {run_length_r, 1'b0};
    if (f_chain) begin
      rl_new = (rl_dbl > RCAP) ? RCAP[dprc_pkg::PC_W-1:0] : rl_dbl[dprc_pkg::PC_W-1:0];
    end else begin
      rl_new = 7'd1;
    end
    f_end_w = {2'b00, page_r} + {1'b0, rl_new};
    f_end   = (f_end_w > {1'b0, n_pages}) ? n_pages : f_end_w[dprc_pkg::PC_W-1:0];
    f_mask  = dprc_pkg::ge_mask({1'b0, page_r}) & dprc_pkg::lt_mask(f_end);
    priority if (f_oor) f_kind = dprc_pkg::KIND_OUT_RANGE;
    else if (f_hit)     f_kind = dprc_pkg::KIND_ALREADY;
    else                f_kind = dprc_pkg::KIND_DIRTIED;
  end

  // scan: next dirty page from pos_r, then the first clean page after it
  logic [dprc_pkg::MAX_PAGES-1:0] find_vec;
  logic [dprc_pkg::MAX_PAGES:0]   clean_vec;
  logic                           more_after;

  assign find_vec   = span_map & dprc_pkg::ge_mask(pos_r);
  assign clean_vec  = {1'b1, ~span_map & dprc_pkg::ge_mask({1'b0, run_first_r})};
  assign more_after = |(span_map & dprc_pkg::ge_mask(run_end_r));

  // run byte window
  logic [dprc_pkg::PC_W-1:0]  r_pages;
  logic [dprc_pkg::OFF_W-1:0] r_span, r_sh, r_gl, r_bc, r_so;
  logic [dprc_pkg::OFF_W:0]   r_top, r_rem;
  logic [dprc_pkg::PG_W-1:0]  r_rel;

  always_comb begin
    r_pages = run_end_r - {1'b0, run_first_r};
    r_span  = {r_pages, {dprc_pkg::PAGE_SHIFT{1'b0}}};
    r_so    = {{(dprc_pkg::OFF_W-dprc_pkg::PAGE_SHIFT){1'b0}},
               cfg_start_r[dprc_pkg::PAGE_SHIFT-1:0]};
    r_top   = {1'b0, cfg_bytes_r} + {1'b0, r_so};
    r_rel   = run_first_r - cfg_first_r;
    if (run_first_r != cfg_first_r) begin
      r_sh  = {1'b0, r_rel, {dprc_pkg::PAGE_SHIFT{1'b0}}};
      r_gl  = r_sh - r_so;
      r_rem = (r_top > {1'b0, r_sh}) ? (r_top - {1'b0, r_sh}) : '0;
      r_bc  = (r_rem > {1'b0, r_span}) ? r_span : r_rem[dprc_pkg::OFF_W-1:0];
    end else begin
      r_sh  = r_so;
      r_gl  = '0;
      r_rem = {1'b0, r_span - r_so};
      r_bc  = (r_rem > {1'b0, cfg_bytes_r}) ? cfg_bytes_r : r_rem[dprc_pkg::OFF_W-1:0];
    end
  end

  logic out_free;
  logic emit_last;
  logic load;

  assign out_free  = !out_valid_r || out_ready;
  assign emit_last = !more_after || (count_r == CNT_LAST);
  assign load      = cmd.fault_load || cmd.emit || cmd.none_load;

  assign sts.out_free   = out_free;
  assign sts.found      = |find_vec;
  assign sts.count_zero = (count_r == '0);
  assign sts.emit_last  = emit_last;

  // tracking state and scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_map_r      <= '0;
      run_length_r     <= 7'd1;
      last_run_end_r   <= '0;
      last_run_valid_r <= 1'b0;
      any_dirty_r      <= 1'b0;
      count_r          <= '0;
    end else begin
      if (cmd.fault_load && (f_kind == dprc_pkg::KIND_DIRTIED)) begin
        dirty_map_r      <= dirty_map_r | f_mask;
        run_length_r     <= rl_new;
        last_run_end_r   <= dprc_pkg::PG_W'(f_end - 7'd1);
        last_run_valid_r <= 1'b1;
        any_dirty_r      <= 1'b1;
      end
      if (cmd.clear) begin
        dirty_map_r      <= '0;
        run_length_r     <= 7'd1;
        last_run_end_r   <= '0;
        last_run_valid_r <= 1'b0;
        any_dirty_r      <= 1'b0;
      end
      if (cmd.accept) begin
        count_r <= '0;
      end else if (cmd.emit) begin
        count_r <= count_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      page_r <= in_page_index;
      pos_r  <= {1'b0, cfg_first_r};
    end
    if (cmd.find) begin
      run_first_r <= dprc_pkg::PG_W'(dprc_pkg::first_set({1'b0, find_vec}));
    end
    if (cmd.extent) begin
      run_end_r <= dprc_pkg::first_set(clean_vec);
      pos_r     <= dprc_pkg::first_set(clean_vec);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fault_load) begin
      out_kind_r  <= f_kind;
      out_first_r <= page_r;
      out_count_r <= (f_kind == dprc_pkg::KIND_DIRTIED) ? (f_end - {1'b0, page_r}) : '0;
      out_bd_r    <= (f_kind == dprc_pkg::KIND_DIRTIED) && !any_dirty_r;
      out_gl_r    <= '0;
      out_sh_r    <= '0;
      out_bc_r    <= '0;
      out_last_r  <= 1'b1;
    end else if (cmd.emit) begin
      out_kind_r  <= dprc_pkg::KIND_RUN;
      out_first_r <= run_first_r;
      out_count_r <= r_pages;
      out_bd_r    <= 1'b0;
      out_gl_r    <= r_gl;
      out_sh_r    <= r_sh;
      out_bc_r    <= r_bc;
      out_last_r  <= emit_last;
    end else if (cmd.none_load) begin
      out_kind_r  <= dprc_pkg::KIND_NONE;
      out_first_r <= '0;
      out_count_r <= '0;
      out_bd_r    <= 1'b0;
      out_gl_r    <= '0;
      out_sh_r    <= '0;
      out_bc_r    <= '0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_first_page    = out_first_r;
  assign out_page_count    = out_count_r;
  assign out_became_dirty  = out_bd_r;
  assign out_gl_offset     = out_gl_r;
  assign out_shadow_offset = out_sh_r;
  assign out_byte_count    = out_bc_r;
  assign out_last          = out_last_r;

  `DPRC_ASSERT_IMP(a_clean_map, clk, rst_n, !any_dirty_r, dirty_map_r == '0)
  `DPRC_ASSERT_NXT(a_clear_all, clk, rst_n, cmd.clear, (dirty_map_r == '0) && !last_run_valid_r)
  `DPRC_ASSERT_NXT(a_fault_mark, clk, rst_n, cmd.fault_load && (f_kind == dprc_pkg::KIND_DIRTIED), dirty_map_r[$past(page_r)] && any_dirty_r)
  `DPRC_ASSERT_IMP(a_run_nonempty, clk, rst_n, cmd.emit, run_end_r > {1'b0, run_first_r})

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 110;   // longest commit plus margin
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    logic                      action;
    logic [dprc_pkg::PG_W-1:0] page;
    bit                        sync;    // sender waits here until every report is back
  } word_t;

  typedef struct {
    dprc_pkg::kind_t            kind;
    logic [dprc_pkg::PG_W-1:0]  first_page;
    logic [dprc_pkg::PC_W-1:0]  page_count;
    logic                       became_dirty;
    logic [dprc_pkg::OFF_W-1:0] gl_offset;
    logic [dprc_pkg::OFF_W-1:0] shadow_offset;
    logic [dprc_pkg::OFF_W-1:0] byte_count;
    logic                       last;
  } report_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [dprc_pkg::IDX_W-1:0]  cfg_index = dprc_pkg::REG_TOTAL_PAGES;
  logic [dprc_pkg::OFF_W-1:0]  cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_action = 1'b0;
  logic [dprc_pkg::PG_W-1:0]   in_page_index = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [dprc_pkg::KIND_W-1:0] out_kind;
  logic [dprc_pkg::PG_W-1:0]   out_first_page;
  logic [dprc_pkg::PC_W-1:0]   out_page_count;
  logic                        out_became_dirty;
  logic [dprc_pkg::OFF_W-1:0]  out_gl_offset;
  logic [dprc_pkg::OFF_W-1:0]  out_shadow_offset;
  logic [dprc_pkg::OFF_W-1:0]  out_byte_count;
  logic                        out_last;

  // tracker copy
  logic [dprc_pkg::MAX_PAGES-1:0] dirty_pages = '0;
  int run_len = 1;
  int run_end = 0;
  bit run_seen = 1'b0;
  bit buffer_dirty = 1'b0;
  int cfg_total = 64;
  int cfg_first = 0;
  int cfg_end = 64;
  int cfg_offset = 0;
  int cfg_bytes = 0;

  word_t   words_to_send[$];
  report_t pending_reports[$];

  int          errors = 0;
  int unsigned ticks = 0;
  bit          in_taken = 1'b0;
  bit          sender_busy = 1'b0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int          send_gap = 0;
  int          ready_gap = 0;

  dirty_page_tracker_run_coalescer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_page_index    (in_page_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_first_page   (out_first_page),
    .out_page_count   (out_page_count),
    .out_became_dirty (out_became_dirty),
    .out_gl_offset    (out_gl_offset),
    .out_shadow_offset(out_shadow_offset),
    .out_byte_count   (out_byte_count),
    .out_last         (out_last)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) ticks <= ticks + 1;

  function automatic void queue_word(word_t w);
    words_to_send = {words_to_send, w};
  endfunction

  function automatic void expect_report(report_t r);
    pending_reports = {pending_reports, r};
  endfunction

  function automatic int page_limit();
    return (cfg_total < dprc_pkg::MAX_PAGES) ? cfg_total : dprc_pkg::MAX_PAGES;
  endfunction

  function automatic report_t make_report(dprc_pkg::kind_t k, int first, int count, bit fresh,
                                          longint gl, longint sh, longint sz, bit fin);
    report_t r;
    r.kind          = k;
    r.first_page    = dprc_pkg::PG_W'(first);
    r.page_count    = dprc_pkg::PC_W'(count);
    r.became_dirty  = fresh;
    r.gl_offset     = dprc_pkg::OFF_W'(gl);
    r.shadow_offset = dprc_pkg::OFF_W'(sh);
    r.byte_count    = dprc_pkg::OFF_W'(sz);
    r.last          = fin;
    return r;
  endfunction

  function automatic void fault_page(int page);
    int  n;
    int  stop;
    int  i;
    bit  fresh;
    n = page_limit();
    if (page >= n) begin
      expect_report(make_report(dprc_pkg::KIND_OUT_RANGE, page, 0, 0, 0, 0, 0, 1));
    end else if (dirty_pages[page]) begin
      expect_report(make_report(dprc_pkg::KIND_ALREADY, page, 0, 0, 0, 0, 0, 1));
    end else begin
      // run doubles only when this fault continues the previous run
      if (run_seen && page > 0 && page == run_end + 1 && dirty_pages[page-1]) begin
        run_len = run_len * 2;
        if (run_len > dprc_pkg::RUN_CAP) run_len = dprc_pkg::RUN_CAP;
      end else begin
        run_len = 1;
      end
      stop = (page + run_len > n) ? n : page + run_len;
      for (i = page; i < stop; i++) dirty_pages[i] = 1'b1;
      run_end = stop - 1;
      run_seen = 1'b1;
      fresh = !buffer_dirty;
      buffer_dirty = 1'b1;
      expect_report(make_report(dprc_pkg::KIND_DIRTIED, page, stop - page, fresh,
                                0, 0, 0, 1));
    end
  endfunction

  function automatic void commit_runs();
    int      n;
    int      stop;
    int      i;
    int      first;
    int      emitted;
    longint  start_off;
    longint  top;
    longint  span;
    longint  gl;
    longint  sh;
    longint  sz;
    report_t held;
    bit      have_held;
    n = page_limit();
    stop = (cfg_end < n) ? cfg_end : n;
    start_off = cfg_offset % dprc_pkg::PAGE_BYTES;
    emitted = 0;
    have_held = 1'b0;
    i = cfg_first;
    while (i < stop) begin
      if (!dirty_pages[i]) begin
        i++;
      end else begin
        first = i;
        while (i < stop && dirty_pages[i]) i++;
        span = longint'(i - first) * dprc_pkg::PAGE_BYTES;
        if (first != cfg_first) begin
          top = start_off + cfg_bytes;
          sh = longint'(first - cfg_first) * dprc_pkg::PAGE_BYTES;
          gl = sh - start_off;
          sz = (top > sh) ? top - sh : 0;
          if (sz > span) sz = span;
        end else begin
          sh = start_off;
          gl = 0;
          sz = span - start_off;
          if (sz > cfg_bytes) sz = cfg_bytes;
        end
        if (emitted < dprc_pkg::RESULT_CAP) begin
          if (have_held) expect_report(held);
          held = make_report(dprc_pkg::KIND_RUN, first, i - first, 0, gl, sh, sz, 0);
          have_held = 1'b1;
          emitted++;
        end
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expect_report(held);
    end else begin
      expect_report(make_report(dprc_pkg::KIND_NONE, 0, 0, 0, 0, 0, 0, 1));
    end
    dirty_pages = '0;
    buffer_dirty = 1'b0;
    run_len = 1;
    run_end = 0;
    run_seen = 1'b0;
  endfunction

  function automatic void compare(string field, logic [dprc_pkg::OFF_W-1:0] want,
                                  logic [dprc_pkg::OFF_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  // monitor: check delivered words, then predict for the word just taken
  always @(posedge clk) begin : monitor
    report_t want;
    in_taken = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result word: kind %0d first_page %0d", out_kind, out_first_page);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        compare("kind", want.kind, out_kind);
        compare("first_page", want.first_page, out_first_page);
        compare("page_count", want.page_count, out_page_count);
        compare("became_dirty", want.became_dirty, out_became_dirty);
        compare("gl_offset", want.gl_offset, out_gl_offset);
        compare("shadow_offset", want.shadow_offset, out_shadow_offset);
        compare("byte_count", want.byte_count, out_byte_count);
        compare("last", want.last, out_last);
      end
    end
    if (in_taken) begin
      if (in_action) commit_runs();
      else fault_page(int'(in_page_index));
    end
  end

  always @(negedge clk) begin : driver
    word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      sender_busy = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (words_to_send.size() != 0 && words_to_send[0].sync) begin
        in_valid <= 1'b0;
        if (pending_reports.size() == 0) void'(words_to_send.pop_front());
      end else if (words_to_send.size() != 0) begin
        nxt = words_to_send.pop_front();
        in_valid <= 1'b1;
        in_action <= nxt.action;
        in_page_index <= nxt.page;
        sender_busy = 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (hold_req) begin
      hold_req = 1'b0;
      ready_gap = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      ready_gap = $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void send_fault(int page);
    queue_word('{action: 1'b0, page: dprc_pkg::PG_W'(page), sync: 1'b0});
  endfunction

  function automatic void send_commit();
    queue_word('{action: 1'b1, page: dprc_pkg::PG_W'($urandom_range(0, 63)), sync: 1'b0});
  endfunction

  function automatic void queue_random(int words);
    int left;
    int start;
    int step;
    int pick;
    int k;
    int hi;
    hi = (page_limit() > 0) ? page_limit() - 1 : 0;
    left = words;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // each fault lands just past the run before it, so the run keeps doubling
        start = $urandom_range(0, hi);
        step = 1;
        for (k = $urandom_range(1, 6);
             k > 0 && start < dprc_pkg::MAX_PAGES && left > 0; k--) begin
          send_fault(start);
          left--;
          start += step;
          step *= 2;
        end
      end else if (pick < 70) begin
        send_fault($urandom_range(0, 63));
        left--;
      end else if (pick < 86) begin
        send_fault($urandom_range(0, hi));
        left--;
      end else begin
        send_commit();
        left--;
      end
    end
    send_commit();
  endfunction

  task automatic settle();
    do @(negedge clk);
    while (words_to_send.size() != 0 || sender_busy || pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [dprc_pkg::IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= dprc_pkg::OFF_W'(value);
    case (idx)
      dprc_pkg::REG_TOTAL_PAGES:  cfg_total  = value & 'h7F;
      dprc_pkg::REG_MAP_FIRST:    cfg_first  = value & 'h3F;
      dprc_pkg::REG_MAP_END:      cfg_end    = value & 'h7F;
      dprc_pkg::REG_START_OFFSET: cfg_offset = value & 'hFFF;
      dprc_pkg::REG_BYTE_COUNT:   cfg_bytes  = value & 'h7FFFF;
      default: ;
    endcase
  endtask

  task automatic reconfigure(int pages, int map_first, int map_end, int offset, int bytes);
    settle();
    write_reg(dprc_pkg::REG_TOTAL_PAGES, pages);
    write_reg(dprc_pkg::REG_MAP_FIRST, map_first);
    write_reg(dprc_pkg::REG_MAP_END, map_end);
    write_reg(dprc_pkg::REG_START_OFFSET, offset);
    write_reg(dprc_pkg::REG_BYTE_COUNT, bytes);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    wait (ticks >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int p;
    int tp;
    int fp;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: empty commit, full doubling chain to the top page, one big run
    send_commit();
    send_fault(0);
    send_fault(1);
    send_fault(3);
    send_fault(7);
    send_fault(15);
    send_fault(31);
    send_fault(63);
    send_fault(5);
    send_fault(63);
    send_commit();

    // smaller buffer, offset window, short mapping
    reconfigure(40, 2, 50, 100, 20000);
    send_fault(40);
    send_fault(63);
    send_fault(0);
    send_fault(39);
    send_fault(2);
    send_fault(3);
    send_fault(5);
    send_fault(20);
    send_fault(10);
    send_fault(11);
    send_commit();
    send_commit();

    // every other page dirty gives the most runs; receiver holds off meanwhile
    reconfigure(64, 0, 64, 4095, 262144);
    for (p = 0; p < dprc_pkg::MAX_PAGES; p += 2) send_fault(p);
    send_commit();
    hold_req = 1'b1;
    queue_random(10);
    queue_word('{action: 1'b0, page: '0, sync: 1'b1});
    queue_random(10);

    reconfigure(1, 0, 1, 0, 4096);
    queue_random(12);

    reconfigure(127, 63, 127, 4095, 262144);
    queue_random(15);

    // map end below map start: span is empty
    reconfigure(64, 50, 20, 5, 1000);
    queue_random(10);

    repeat (3) begin
      tp = $urandom_range(1, 64);
      fp = $urandom_range(0, 31);
      reconfigure(tp, fp, $urandom_range(fp + 1, 64), $urandom_range(0, 4095),
                  $urandom_range(0, 262144));
      queue_random(10);
    end

    reconfigure(64, $urandom_range(0, 15), 64, $urandom_range(0, 4095),
                $urandom_range(0, 262144));
    quiet = 1'b1;
    queue_random(25);

    settle();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== dirty_page_tracker_run_coalescer_unit.f =====
+incdir+design
design/dprc_pkg.sv
design/dprc_ctrl.sv
design/dprc_dp.sv
design/dirty_page_tracker_run_coalescer_unit.sv
tb/tb_top.sv
